[hw/rtl/cdlc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdlc_pkg
// Shared types, constants and the half-round function of the Chaskey
// differential-linear correlation counter.
// ----------------------------------------------------------------------------
package cdlc_pkg;

  localparam int unsigned WORD_W        = 32;
  localparam int unsigned MASK_W        = 64;
  localparam int unsigned ROUND_W       = 5;
  localparam int unsigned COUNT_W       = 48;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned FIFO_DEPTH    = 2;
  localparam int unsigned MAX_HALF_ROUNDS_DEF = 16;

  // Rotation amounts of one half-round.
  localparam int unsigned ROT_A_EVEN = 8;
  localparam int unsigned ROT_A_ODD  = 13;
  localparam int unsigned ROT_B_EVEN = 5;
  localparam int unsigned ROT_B_ODD  = 7;
  localparam int unsigned ROT_SWAP   = 16;

  localparam logic [ROUND_W-1:0] END_HR_RESET = ROUND_W'(8);

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
  localparam logic signed [COUNT_W-1:0] COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_MASK_LOW    = 3'd0,
    REG_DIFF_MASK_HIGH   = 3'd1,
    REG_OUT_MASK_LOW     = 3'd2,
    REG_OUT_MASK_HIGH    = 3'd3,
    REG_FIRST_HALF_ROUND = 3'd4,
    REG_END_HALF_ROUND   = 3'd5
  } cfg_idx_e;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
  } state_t;

  // The plain state and its copy with the input difference applied.
  typedef struct packed {
    state_t a;
    state_t b;
  } pair_t;

  typedef struct packed {
    logic [MASK_W-1:0]  diff_mask_low;
    logic [MASK_W-1:0]  diff_mask_high;
    logic [MASK_W-1:0]  out_mask_low;
    logic [MASK_W-1:0]  out_mask_high;
    logic [ROUND_W-1:0] first_half_round;
    logic [ROUND_W-1:0] end_half_round;
  } cfg_t;

  // Left rotation by a constant amount between 1 and 31.
  function automatic word_t rotl(word_t x, int unsigned s);
    return (x << s) | (x >> (WORD_W - s));
  endfunction

  // One Chaskey half-round; odd selects the rotation pair of odd numbers.
  function automatic state_t half_round(state_t v, logic odd);
    word_t  z0;
    word_t  z1;
    word_t  r1;
    word_t  r3;
    state_t r;
    z0   = v.w0 + v.w1;
    z1   = v.w2 + v.w3;
    r1   = odd ? rotl(v.w1, ROT_A_ODD) : rotl(v.w1, ROT_A_EVEN);
    r3   = odd ? rotl(v.w3, ROT_B_ODD) : rotl(v.w3, ROT_B_EVEN);
    r.w0 = rotl(z1, ROT_SWAP);
    r.w1 = z0 ^ r1;
    r.w2 = z0;
    r.w3 = z1 ^ r3;
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/cdlc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdlc_in_if
// Input channel: one beat carries one 128-bit state as four words.
// ----------------------------------------------------------------------------
interface cdlc_in_if;
  logic                 valid;
  logic                 ready;
  cdlc_pkg::word_t      word0;
  cdlc_pkg::word_t      word1;
  cdlc_pkg::word_t      word2;
  cdlc_pkg::word_t      word3;

  modport source (output valid, output word0, output word1, output word2,
                  output word3, input ready);
  modport sink   (input valid, input word0, input word1, input word2,
                  input word3, output ready);
endinterface
`default_nettype wire

[hw/rtl/cdlc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdlc_out_if
// Result channel: parity, running count and output difference words.
// ----------------------------------------------------------------------------
interface cdlc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   parity_bit;
  logic signed [cdlc_pkg::COUNT_W-1:0]    running_count;
  cdlc_pkg::word_t                        diff_word0;
  cdlc_pkg::word_t                        diff_word1;
  cdlc_pkg::word_t                        diff_word2;
  cdlc_pkg::word_t                        diff_word3;

  modport source (output valid, output parity_bit, output running_count,
                  output diff_word0, output diff_word1, output diff_word2,
                  output diff_word3, input ready);
  modport sink   (input valid, input parity_bit, input running_count,
                  input diff_word0, input diff_word1, input diff_word2,
                  input diff_word3, output ready);
endinterface
`default_nettype wire

[hw/rtl/cdlc_cfg_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdlc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cdlc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [cdlc_pkg::CFG_IDX_W-1:0]     index;
  logic [cdlc_pkg::MASK_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/cdlc_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdlc_front
// Holds the configuration registers, takes input beats and forms the pair of
// states (plain and with the input difference) for the queue.
// ----------------------------------------------------------------------------
module cdlc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  cdlc_cfg_if.sink             cfg_bus,
  cdlc_in_if.sink              in_bus,
  output cdlc_pkg::cfg_t       cfg,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output cdlc_pkg::pair_t      push_pair
);

  cdlc_pkg::cfg_t  cfg_r;
  cdlc_pkg::cfg_t  cfg_nxt;
  logic            valid_r;
  cdlc_pkg::pair_t pair_r;
  cdlc_pkg::pair_t pair_nxt;
  logic            take;

  // Register writes are always taken.
  assign cfg_bus.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      case (cdlc_pkg::cfg_idx_e'(cfg_bus.index))
        cdlc_pkg::REG_DIFF_MASK_LOW:    cfg_nxt.diff_mask_low  = cfg_bus.data;
        cdlc_pkg::REG_DIFF_MASK_HIGH:   cfg_nxt.diff_mask_high = cfg_bus.data;
        cdlc_pkg::REG_OUT_MASK_LOW:     cfg_nxt.out_mask_low   = cfg_bus.data;
        cdlc_pkg::REG_OUT_MASK_HIGH:    cfg_nxt.out_mask_high  = cfg_bus.data;
        cdlc_pkg::REG_FIRST_HALF_ROUND: begin
          cfg_nxt.first_half_round = cfg_bus.data[cdlc_pkg::ROUND_W-1:0];
        end
        cdlc_pkg::REG_END_HALF_ROUND: begin
          cfg_nxt.end_half_round = cfg_bus.data[cdlc_pkg::ROUND_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.diff_mask_low    <= '0;
      cfg_r.diff_mask_high   <= '0;
      cfg_r.out_mask_low     <= '0;
      cfg_r.out_mask_high    <= '0;
      cfg_r.first_half_round <= '0;
      cfg_r.end_half_round   <= cdlc_pkg::END_HR_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // The input stage refills whenever it is empty or its beat moves on.
  assign in_bus.ready = !valid_r || push_ready;
  assign take         = in_bus.valid && in_bus.ready;

  always_comb begin
    pair_nxt.a.w0 = in_bus.word0;
    pair_nxt.a.w1 = in_bus.word1;
    pair_nxt.a.w2 = in_bus.word2;
    pair_nxt.a.w3 = in_bus.word3;
    pair_nxt.b.w0 = in_bus.word0 ^ cfg_r.diff_mask_low[cdlc_pkg::WORD_W-1:0];
    pair_nxt.b.w1 = in_bus.word1 ^ cfg_r.diff_mask_low[cdlc_pkg::MASK_W-1:cdlc_pkg::WORD_W];
    pair_nxt.b.w2 = in_bus.word2 ^ cfg_r.diff_mask_high[cdlc_pkg::WORD_W-1:0];
    pair_nxt.b.w3 = in_bus.word3 ^ cfg_r.diff_mask_high[cdlc_pkg::MASK_W-1:cdlc_pkg::WORD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pair_r <= pair_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_pair  = pair_r;

endmodule
`default_nettype wire

[hw/rtl/cdlc_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdlc_fifo
// Short queue of state pairs between the front and the round pipeline.
// ----------------------------------------------------------------------------
module cdlc_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire cdlc_pkg::pair_t push_pair,
  output logic                 pop_valid,
  input  wire logic            pop,
  output cdlc_pkg::pair_t      pop_pair
);

  localparam int unsigned DEPTH = cdlc_pkg::FIFO_DEPTH;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  cdlc_pkg::pair_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_pair   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer wrap at the end of the queue.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_pair;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/cdlc_hr_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdlc_hr_stage
// One pipeline stage: applies half-round number STAGE to both states of the
// pair when that number lies inside the configured range.
// ----------------------------------------------------------------------------
module cdlc_hr_stage #(
  parameter int unsigned STAGE = 0,
  parameter int unsigned RW    = 5
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic [RW-1:0]   lo,
  input  wire logic [RW-1:0]   hi,
  input  wire logic            in_valid,
  input  wire cdlc_pkg::pair_t in_pair,
  output logic                 out_valid,
  output cdlc_pkg::pair_t      out_pair
);

  localparam logic [RW-1:0] IDX = RW'(STAGE);
  localparam logic          ODD = ((STAGE % 2) == 1);

  logic            valid_r;
  cdlc_pkg::pair_t pair_r;
  cdlc_pkg::pair_t pair_nxt;
  logic            apply;

  assign apply = (IDX >= lo) && (IDX < hi);

  always_comb begin
    pair_nxt = in_pair;
    if (apply) begin
      pair_nxt.a = cdlc_pkg::half_round(in_pair.a, ODD);
      pair_nxt.b = cdlc_pkg::half_round(in_pair.b, ODD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_r <= pair_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pair  = pair_r;

endmodule
`default_nettype wire

[hw/rtl/cdlc_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdlc_back
// Round pipeline, output difference and parity stage, and the saturating
// agreement counter with the result register.
// ----------------------------------------------------------------------------
module cdlc_back #(
  parameter int unsigned MAX_HALF_ROUNDS = cdlc_pkg::MAX_HALF_ROUNDS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cdlc_pkg::cfg_t  cfg,
  input  wire logic            fifo_valid,
  input  wire cdlc_pkg::pair_t fifo_pair,
  output logic                 fifo_pop,
  cdlc_out_if.source           out_bus
);

  localparam int unsigned N  = MAX_HALF_ROUNDS;
  localparam int unsigned RW = $clog2(N + 1);
  localparam int unsigned CW = (RW > cdlc_pkg::ROUND_W) ? RW : cdlc_pkg::ROUND_W;
  localparam logic [CW-1:0] NC = CW'(N);

  logic            en;
  logic [CW-1:0]   first_ext;
  logic [CW-1:0]   end_ext;
  logic [CW-1:0]   lo_c;
  logic [CW-1:0]   hi_c;
  logic [RW-1:0]   lo;
  logic [RW-1:0]   hi;
  logic            stg_valid [N+1];
  cdlc_pkg::pair_t stg_pair  [N+1];

  logic            dv_r;
  cdlc_pkg::state_t d_r;
  cdlc_pkg::state_t d_nxt;
  logic            par_r;
  logic            par_nxt;

  logic                                   out_valid_r;
  logic                                   out_par_r;
  cdlc_pkg::state_t                       out_d_r;
  logic signed [cdlc_pkg::COUNT_W-1:0]    count_r;
  logic signed [cdlc_pkg::COUNT_W-1:0]    count_nxt;

  // The whole back end moves while the result register is free or drained.
  assign en       = !out_valid_r || out_bus.ready;
  assign fifo_pop = en && fifo_valid;

  // Both round bounds saturate at the number of stages.
  assign first_ext = CW'(cfg.first_half_round);
  assign end_ext   = CW'(cfg.end_half_round);
  assign lo_c      = (first_ext > NC) ? NC : first_ext;
  assign hi_c      = (end_ext > NC) ? NC : end_ext;
  assign lo        = lo_c[RW-1:0];
  assign hi        = hi_c[RW-1:0];

  assign stg_valid[0] = fifo_valid;
  assign stg_pair[0]  = fifo_pair;

  // One stage per half-round number.
  for (genvar s = 0; s < N; s++) begin : g_stage
    cdlc_hr_stage #(
      .STAGE (s),
      .RW    (RW)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .lo        (lo),
      .hi        (hi),
      .in_valid  (stg_valid[s]),
      .in_pair   (stg_pair[s]),
      .out_valid (stg_valid[s+1]),
      .out_pair  (stg_pair[s+1])
    );
  end

  // Output difference and its masked parity.
  always_comb begin
    d_nxt   = stg_pair[N].a ^ stg_pair[N].b;
    par_nxt = ^(({d_nxt.w1, d_nxt.w0} & cfg.out_mask_low) ^
                ({d_nxt.w3, d_nxt.w2} & cfg.out_mask_high));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= 1'b0;
    end else if (en) begin
      dv_r <= stg_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_nxt;
      par_r <= par_nxt;
    end
  end

  // Saturating count: up on even parity, down on odd parity.
  always_comb begin
    count_nxt = count_r;
    if (!par_r) begin
      if (count_r != cdlc_pkg::COUNT_MAX) begin
        count_nxt = count_r + cdlc_pkg::COUNT_W'(1);
      end
    end else begin
      if (count_r != cdlc_pkg::COUNT_MIN) begin
        count_nxt = count_r - cdlc_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else if (en) begin
      out_valid_r <= dv_r;
      if (dv_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && dv_r) begin
      out_par_r <= par_r;
      out_d_r   <= d_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.parity_bit    = out_par_r;
  assign out_bus.running_count = count_r;
  assign out_bus.diff_word0    = out_d_r.w0;
  assign out_bus.diff_word1    = out_d_r.w1;
  assign out_bus.diff_word2    = out_d_r.w2;
  assign out_bus.diff_word3    = out_d_r.w3;

endmodule
`default_nettype wire

[hw/rtl/chaskey_differential_linear_counter_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chaskey_differential_linear_counter_top
// Chaskey differential-linear correlation counter, top level.
// ----------------------------------------------------------------------------
// The block takes one 128-bit state per beat and returns one result per beat:
// the masked output-difference parity, the saturating agreement count after
// that state, and the four output difference words. It sustains one beat per
// clock cycle while results are taken; the round pipeline has one registered
// stage per half-round (MAX_HALF_ROUNDS stages) and stages outside the
// configured range pass the pair through unchanged. A short queue sits
// between the input stage and the pipeline, and the result register holds a
// finished beat while new input is still taken. Configuration writes are
// always accepted and must only be made while no beat is in flight.
// ----------------------------------------------------------------------------
module chaskey_differential_linear_counter_top #(
  parameter int unsigned MAX_HALF_ROUNDS = cdlc_pkg::MAX_HALF_ROUNDS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  cdlc_cfg_if.sink      cfg_bus,
  cdlc_in_if.sink       in_bus,
  cdlc_out_if.source    out_bus
);

  cdlc_pkg::cfg_t  cfg;
  logic            push_valid;
  logic            push_ready;
  cdlc_pkg::pair_t push_pair;
  logic            pop_valid;
  logic            pop;
  cdlc_pkg::pair_t pop_pair;

  // Input stage and configuration registers.
  cdlc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_bus    (cfg_bus),
    .in_bus     (in_bus),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pair  (push_pair)
  );

  // Decoupling queue.
  cdlc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_pair  (push_pair),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_pair   (pop_pair)
  );

  // Round pipeline, parity and counter.
  cdlc_back #(
    .MAX_HALF_ROUNDS (MAX_HALF_ROUNDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .fifo_valid (pop_valid),
    .fifo_pair  (pop_pair),
    .fifo_pop   (pop),
    .out_bus    (out_bus)
  );

endmodule
`default_nettype wire
